### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers for the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion disabled while reset is asserted (active low)
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// assertion that is also checked across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/aes_sbox_pkg.sv
// ---------------------------------------------------------------------------
// aes s-box package
// field constants and helper functions for the forward s-box block
// ---------------------------------------------------------------------------
package aes_sbox_pkg;

  localparam int unsigned BYTE_W = 8;

  typedef logic [BYTE_W-1:0] byte_t;

  // reduction term of x^8+x^4+x^3+x+1 once the top bit is dropped
  localparam byte_t GF_REDUCE    = 8'h1b;
  localparam byte_t AFFINE_CONST = 8'h63;
  localparam byte_t LOG_MAX      = 8'hff;

  // requests that can be in flight at once: two ram stages plus output
  localparam int unsigned MAX_INFLIGHT = 3;
  localparam int unsigned INFLIGHT_W   = 3;

  // multiply by x in gf(2^8)
  function automatic byte_t gf_xtime(input byte_t v);
    gf_xtime = {v[BYTE_W-2:0], 1'b0} ^ (v[BYTE_W-1] ? GF_REDUCE : 8'h00);
  endfunction

  // affine transform: xor with left rotations by 1..4 and the constant
  function automatic byte_t sbox_affine(input byte_t v);
    sbox_affine = v
                ^ {v[6:0], v[7]}
                ^ {v[5:0], v[7:6]}
                ^ {v[4:0], v[7:5]}
                ^ {v[3:0], v[7:4]}
                ^ AFFINE_CONST;
  endfunction

endpackage

### hdl/aes_sbox_ram.sv
// ---------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module aes_sbox_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/aes_forward_sbox.sv
// ---------------------------------------------------------------------------
// aes forward s-box
// byte substitution through log / antilog rams and the aes affine transform
// ---------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_ready, in_byte[7:0]        | request in
//  out     | out_valid, out_ready, out_sub_byte[7:0] | result out
//
//  one request per cycle sustained while out_ready stays high; after the accepting
//  edge a request passes the log ram read, antilog ram read and output register
//  after reset the log and antilog rams are built in a sweep over all 256 entries
//  (generator 3); in_ready stays low until the sweep is done
//  each stage only holds when the stage behind it is full and stalled, so
//  new requests are taken while a finished result waits in the output register
//
module aes_forward_sbox (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  aes_sbox_pkg::byte_t in_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output aes_sbox_pkg::byte_t out_sub_byte
);

  import aes_sbox_pkg::*;

  // fill sweep: counter runs 0..256, bit 8 marks the tables as built
  logic [BYTE_W:0] fill_cnt_r, fill_cnt_nxt;
  byte_t           gen_r, gen_nxt;      // current power of the generator
  logic            fill_done;

  // pipeline control
  logic  s1_v_r, s1_v_nxt;              // log ram data valid
  logic  s2_v_r, s2_v_nxt;              // antilog ram data valid
  logic  out_v_r, out_v_nxt;
  logic  s1_zero_r, s2_zero_r;          // zero has no log, forced to inverse zero
  byte_t out_data_r;

  logic  en1, en2, en_out;
  logic  in_acc;

  // ram ports
  logic  log_we, alog_we;
  byte_t log_rdata, alog_rdata;
  byte_t alog_raddr;
  byte_t inv_byte;

  assign fill_done = fill_cnt_r[BYTE_W];

  // each stage loads when it is empty or its contents move on
  assign en_out = !out_v_r || out_ready;
  assign en2    = !s2_v_r  || en_out;
  assign en1    = !s1_v_r  || en2;

  assign in_ready = fill_done && en1;
  assign in_acc   = in_valid && in_ready;

  // sweep writes alog[i] = 3^i for i in 0..255 and log[3^i] = i for i < 255
  assign alog_we = !fill_done;
  assign log_we  = !fill_done && (fill_cnt_r[BYTE_W-1:0] != LOG_MAX);

  always_comb begin
    fill_cnt_nxt = fill_cnt_r;
    gen_nxt      = gen_r;
    if (!fill_done) begin
      fill_cnt_nxt = fill_cnt_r + 1'b1;
      gen_nxt      = gen_r ^ gf_xtime(gen_r);   // multiply by 3
    end
  end

  // inverse exponent is 255 - log; zero steered to a written entry
  assign alog_raddr = s1_zero_r ? LOG_MAX : (LOG_MAX - log_rdata);

  aes_sbox_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (1 << BYTE_W)
  ) u_log_ram (
    .clk   (clk),
    .we    (log_we),
    .waddr (gen_r),
    .wdata (fill_cnt_r[BYTE_W-1:0]),
    .re    (en1),
    .raddr (in_byte),
    .rdata (log_rdata)
  );

  aes_sbox_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (1 << BYTE_W)
  ) u_alog_ram (
    .clk   (clk),
    .we    (alog_we),
    .waddr (fill_cnt_r[BYTE_W-1:0]),
    .wdata (gen_r),
    .re    (en2),
    .raddr (alog_raddr),
    .rdata (alog_rdata)
  );

  assign inv_byte = s2_zero_r ? 8'h00 : alog_rdata;

  always_comb begin
    s1_v_nxt  = en1    ? in_acc : s1_v_r;
    s2_v_nxt  = en2    ? s1_v_r : s2_v_r;
    out_v_nxt = en_out ? s2_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
      gen_r      <= 8'h01;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      fill_cnt_r <= fill_cnt_nxt;
      gen_r      <= gen_nxt;
      s1_v_r     <= s1_v_nxt;
      s2_v_r     <= s2_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_zero_r <= (in_byte == 8'h00);
    end
    if (en2) begin
      s2_zero_r <= s1_zero_r;
    end
    if (en_out) begin
      out_data_r <= sbox_affine(inv_byte);
    end
  end

  assign out_valid    = out_v_r;
  assign out_sub_byte = out_data_r;

endmodule

### hdl/aes_sbox_checker.sv
// ---------------------------------------------------------------------------
// aes s-box checker
// port level checks on request flow and result hold, bound to the top
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aes_sbox_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input aes_sbox_pkg::byte_t in_byte,
  input logic                out_valid,
  input logic                out_ready,
  input aes_sbox_pkg::byte_t out_sub_byte
);

  import aes_sbox_pkg::*;

  // requests accepted but not yet delivered
  logic [INFLIGHT_W-1:0] inflight_r, inflight_nxt;
  logic                  in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // stalled result holds its value
  `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_sub_byte), "stalled result changed")

  // no result without an outstanding request
  `ASSERT_RST(a_no_extra, clk, rst_n, out_valid |-> inflight_r != '0, "result without request")

  // pipeline depth bounds the outstanding requests
  `ASSERT_RST(a_depth, clk, rst_n, inflight_r <= INFLIGHT_W'(MAX_INFLIGHT), "too many requests in flight")

  // tables are rebuilt after reset: nothing taken or shown straight away
  `ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !in_ready && !out_valid, "busy after reset")

endmodule

bind aes_forward_sbox aes_sbox_checker u_aes_sbox_checker (.*);

### tb/sv/aes_forward_sbox_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aes forward s-box testbench
// drives bytes through the valid/ready request channel and checks every
// substituted byte against typed-in values or a field-arithmetic s-box in the bench
// ---------------------------------------------------------------------------
module aes_forward_sbox_tb;

  import aes_sbox_pkg::*;

  localparam int RANDOM_BYTES  = 850;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int TAIL_CYCLES   = 8;
  localparam int SHOW_LIMIT    = 10;
  localparam int HOLD_AT       = 300;  // results seen before the long hold-off
  localparam int HOLD_CYCLES   = 400;
  localparam byte_t POLY_LOW   = 8'h1b;
  localparam byte_t AFFINE_XOR = 8'h63;

  typedef struct {
    byte_t din;
    bit    known;  // expected value typed in below
    byte_t sub;
  } sbox_row_t;

  logic  clk;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  byte_t in_byte   = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  byte_t out_sub_byte;

  // substituted bytes still owed by the block, oldest first
  byte_t sub_bytes_due[$];
  // typed-in values for the first rows, in acceptance order (0 = use predictor)
  bit    known_due[$];
  byte_t known_val_due[$];

  int    fault_count  = 0;
  int    shown_count  = 0;
  int    results_seen = 0;
  int    cycle_count  = 0;

  // directed rows: zero, one, the top byte and the top bit are typed in,
  // the rest go through the predictor
  sbox_row_t directed_rows[] = '{
    '{8'h00, 1'b1, 8'h63},  // zero has no inverse, taken as zero
    '{8'h01, 1'b1, 8'h7c},  // one is its own inverse
    '{8'hff, 1'b1, 8'h16},
    '{8'h80, 1'b1, 8'hcd},
    '{8'h7f, 1'b0, 8'h00},
    '{8'hfe, 1'b0, 8'h00},
    '{8'h02, 1'b0, 8'h00},
    '{8'h03, 1'b0, 8'h00},  // the table generator
    '{8'h04, 1'b0, 8'h00},
    '{8'h08, 1'b0, 8'h00},
    '{8'h10, 1'b0, 8'h00},
    '{8'h20, 1'b0, 8'h00},
    '{8'h40, 1'b0, 8'h00},
    '{8'h55, 1'b0, 8'h00},
    '{8'haa, 1'b0, 8'h00},
    '{8'h0f, 1'b0, 8'h00},
    '{8'hf0, 1'b0, 8'h00},
    '{8'h1b, 1'b0, 8'h00},  // the reduction term itself
    '{8'h8d, 1'b0, 8'h00},
    '{8'hf6, 1'b0, 8'h00}
  };

  aes_forward_sbox uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sub_byte (out_sub_byte)
  );

  // ---------------------------------------------------------------------------
  // predictor: inverse as b^254 by shift-and-add multiply, then affine map
  // ---------------------------------------------------------------------------
  function automatic byte_t gf_product(input byte_t a, input byte_t b);
    byte_t acc;
    byte_t x;
    acc = '0;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? POLY_LOW : 8'h00);
    end
    return acc;
  endfunction

  function automatic byte_t sbox_lookup(input byte_t v);
    byte_t sq;
    byte_t inv;
    byte_t rot;
    byte_t res;
    // v^254 = v^2 * v^4 * ... * v^128, zero falls out as zero
    sq  = gf_product(v, v);
    inv = sq;
    for (int k = 0; k < 6; k++) begin
      sq  = gf_product(sq, sq);
      inv = gf_product(inv, sq);
    end
    res = inv ^ AFFINE_XOR;
    rot = inv;
    for (int r = 1; r <= 4; r++) begin
      rot = {rot[6:0], rot[7]};
      res ^= rot;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // watchdog: covers the ram build sweep, stalls and the long hold-off
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sub_bytes_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sender: bursts of requests with random gaps, valid held until accepted
  // ---------------------------------------------------------------------------
  task automatic offer_byte(input byte_t b, input bit known, input byte_t val,
                            inout int burst_left);
    int gap;
    in_valid <= 1'b1;
    in_byte  <= b;
    // the typed value travels with the request into the checker's queue
    known_due.push_back(known);
    known_val_due.push_back(val);
    do @(posedge clk); while (!in_ready);
    // accepted at this edge: maybe leave a gap before the next request
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_byte  <= byte_t'($urandom);  // noise on an idle bus
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    int    burst_left;
    byte_t b;
    burst_left = $urandom_range(1, 24);
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    foreach (directed_rows[i])
      offer_byte(directed_rows[i].din, directed_rows[i].known, directed_rows[i].sub,
                 burst_left);

    for (int n = 0; n < RANDOM_BYTES; n++) begin
      case ($urandom_range(0, 9))
        0:       b = $urandom_range(0, 1) ? 8'h00 : 8'hff;
        1:       b = byte_t'(1) << $urandom_range(0, 7);
        default: b = byte_t'($urandom_range(0, 255));
      endcase
      offer_byte(b, 1'b0, 8'h00, burst_left);
    end
    in_valid <= 1'b0;

    // drain: let the checker see the last acceptance, then wait it out
    @(posedge clk);
    while (sub_bytes_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sub_bytes_due.size() != 0) fault_count++;

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: ready pattern changes between phases, one long hold-off so the
  // pipeline fills up and in_ready drops while the sender keeps offering
  // ---------------------------------------------------------------------------
  int  ready_pct  = 100;
  int  phase_left = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pct <= 100;
          1:       ready_pct <= 75;
          2:       ready_pct <= 50;
          default: ready_pct <= 20;
        endcase
        phase_left <= $urandom_range(16, 96);
      end else begin
        phase_left <= phase_left - 1;
      end
      out_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // checker: pops the oldest due byte on each result, then records the
  // request accepted at the same edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (sub_bytes_due.size() == 0) begin
        fault_count++;
        if (shown_count < SHOW_LIMIT) begin
          shown_count++;
          $display("unexpected result %02h with nothing outstanding", out_sub_byte);
        end
      end else begin
        want = sub_bytes_due.pop_front();
        if (out_sub_byte !== want) begin
          fault_count++;
          if (shown_count < SHOW_LIMIT) begin
            shown_count++;
            $display("sub_byte mismatch: expected %02h, got %02h", want, out_sub_byte);
          end
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      if (known_due.size() != 0 && known_due.pop_front())
        sub_bytes_due.push_back(known_val_due.pop_front());
      else begin
        if (known_val_due.size() != 0) void'(known_val_due.pop_front());
        sub_bytes_due.push_back(sbox_lookup(in_byte));
      end
    end
  end

endmodule

### sim.f
+incdir+hdl
hdl/aes_sbox_pkg.sv
hdl/aes_sbox_ram.sv
hdl/aes_forward_sbox.sv
hdl/aes_sbox_checker.sv
tb/sv/aes_forward_sbox_tb.sv
